### sv/rsapg_pkg.sv
// Shared constants and controller/datapath interface types for the private exponent generator.
package rsapg_pkg;

  localparam int PRIME_BITS = 16;
  localparam int WORD_BITS  = 32;
  localparam int COEF_BITS  = WORD_BITS + 2;
  localparam logic [WORD_BITS-1:0] MIN_EXPONENT = 32'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_GCD_STEP,
    OP_LCM_DIV,
    OP_LCM_MUL,
    OP_MOD_START,
    OP_INV_SET,
    OP_INV_MUL,
    OP_INV_SUB,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic y_zero;
    logic prime_small;
    logic range_ok;
  } dp_status_t;

endpackage

### sv/rsapg_divider.sv
// Restoring divider, one quotient bit per cycle.
module rsapg_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rsapg_pkg::WORD_BITS-1:0] dividend,
  input  logic [rsapg_pkg::WORD_BITS-1:0] divisor,
  output logic                           done,
  output logic [rsapg_pkg::WORD_BITS-1:0] quotient,
  output logic [rsapg_pkg::WORD_BITS-1:0] remainder
);
  import rsapg_pkg::*;

  localparam int CNT_BITS = $clog2(WORD_BITS);

  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  logic [WORD_BITS-1:0] dvs;
  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   diff;

  assign shifted = {remainder, quotient[WORD_BITS-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(WORD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      if (!diff[WORD_BITS]) begin
        remainder <= diff[WORD_BITS-1:0];
        quotient  <= {quotient[WORD_BITS-2:0], 1'b1};
      end else begin
        remainder <= shifted[WORD_BITS-1:0];
        quotient  <= {quotient[WORD_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

### sv/rsapg_datapath.sv
// Datapath: operand registers, Euclid coefficient registers, multipliers and shared divider.
module rsapg_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  rsapg_pkg::dp_cmd_t              cmd,
  output rsapg_pkg::dp_status_t           status,
  input  logic [rsapg_pkg::WORD_BITS-1:0]  public_exponent,
  input  logic [rsapg_pkg::PRIME_BITS-1:0] prime_one,
  input  logic [rsapg_pkg::PRIME_BITS-1:0] prime_two,
  output logic [rsapg_pkg::WORD_BITS-1:0]  modulus,
  output logic [rsapg_pkg::WORD_BITS-1:0]  carmichael_value,
  output logic [rsapg_pkg::WORD_BITS-1:0]  private_exponent,
  output logic                            key_valid
);
  import rsapg_pkg::*;

  logic [WORD_BITS-1:0]  ereg;
  logic [PRIME_BITS-1:0] a;
  logic [PRIME_BITS-1:0] b;
  logic                  prime_small;
  logic [WORD_BITS-1:0]  x;
  logic [WORD_BITS-1:0]  y;
  logic signed [COEF_BITS-1:0] t;
  logic signed [COEF_BITS-1:0] nt;
  logic signed [COEF_BITS-1:0] prod;
  logic signed [COEF_BITS-1:0] t_fix;
  logic signed [WORD_BITS+COEF_BITS:0] prod_full;
  logic [2*PRIME_BITS-1:0] n_full;
  logic [2*PRIME_BITS-1:0] lcm_full;

  logic                 div_start;
  logic [WORD_BITS-1:0] div_a;
  logic [WORD_BITS-1:0] div_b;
  logic                 div_done;
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] rem;

  rsapg_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    div_start = 1'b0;
    div_a     = x;
    div_b     = y;
    case (cmd.op)
      OP_DIV: div_start = 1'b1;
      OP_LCM_DIV: begin
        div_start = 1'b1;
        div_a     = WORD_BITS'(a);
        div_b     = x;
      end
      OP_MOD_START: begin
        div_start = 1'b1;
        div_a     = ereg;
        div_b     = carmichael_value;
      end
      default: div_start = 1'b0;
    endcase
  end

  assign n_full    = prime_one * prime_two;
  assign lcm_full  = quo[PRIME_BITS-1:0] * b;
  assign prod_full = $signed({1'b0, quo}) * nt;
  assign t_fix     = (t < 0) ? t + $signed(COEF_BITS'(carmichael_value)) : t;

  assign status.div_done    = div_done;
  assign status.y_zero      = (y == '0);
  assign status.prime_small = prime_small;
  assign status.range_ok    = (ereg >= MIN_EXPONENT) && (ereg < modulus);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        ereg             <= public_exponent;
        a                <= prime_one - 1'b1;
        b                <= prime_two - 1'b1;
        prime_small      <= (prime_one < PRIME_BITS'(2)) || (prime_two < PRIME_BITS'(2));
        modulus          <= WORD_BITS'(n_full);
        x                <= WORD_BITS'(prime_one - 1'b1);
        y                <= WORD_BITS'(prime_two - 1'b1);
        carmichael_value <= '0;
        private_exponent <= '0;
        key_valid        <= 1'b0;
      end
      OP_GCD_STEP: begin
        x <= y;
        y <= rem;
      end
      OP_LCM_MUL: carmichael_value <= WORD_BITS'(lcm_full);
      OP_INV_SET: begin
        x  <= carmichael_value;
        y  <= rem;
        t  <= '0;
        nt <= COEF_BITS'(1);
      end
      OP_INV_MUL: begin
        prod <= prod_full[COEF_BITS-1:0];
        x    <= y;
        y    <= rem;
      end
      OP_INV_SUB: begin
        t  <= nt;
        nt <= t - prod;
      end
      OP_FINISH: begin
        // gcd(e, lambda) ends up in x
        if (x == WORD_BITS'(1)) begin
          key_valid        <= 1'b1;
          private_exponent <= t_fix[WORD_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

### sv/rsapg_ctrl.sv
// Controller state machine sequencing the gcd, lcm, range check and inverse.
module rsapg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  rsapg_pkg::dp_status_t status,
  output rsapg_pkg::dp_cmd_t    cmd
);
  import rsapg_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CHECK  = 11'b00000000010,
    S_G_TEST = 11'b00000000100,
    S_G_WAIT = 11'b00000001000,
    S_L_WAIT = 11'b00000010000,
    S_RANGE  = 11'b00000100000,
    S_M_WAIT = 11'b00001000000,
    S_I_TEST = 11'b00010000000,
    S_I_WAIT = 11'b00100000000,
    S_I_SUB  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = status.prime_small ? S_DONE : S_G_TEST;
      S_G_TEST: begin
        if (status.y_zero) begin
          cmd.op     = OP_LCM_DIV;
          state_next = S_L_WAIT;
        end else begin
          cmd.op     = OP_DIV;
          state_next = S_G_WAIT;
        end
      end
      S_G_WAIT: begin
        if (status.div_done) begin
          cmd.op     = OP_GCD_STEP;
          state_next = S_G_TEST;
        end
      end
      S_L_WAIT: begin
        if (status.div_done) begin
          cmd.op     = OP_LCM_MUL;
          state_next = S_RANGE;
        end
      end
      S_RANGE: begin
        if (status.range_ok) begin
          cmd.op     = OP_MOD_START;
          state_next = S_M_WAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_M_WAIT: begin
        if (status.div_done) begin
          cmd.op     = OP_INV_SET;
          state_next = S_I_TEST;
        end
      end
      S_I_TEST: begin
        if (status.y_zero) begin
          cmd.op     = OP_FINISH;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_DIV;
          state_next = S_I_WAIT;
        end
      end
      S_I_WAIT: begin
        if (status.div_done) begin
          cmd.op     = OP_INV_MUL;
          state_next = S_I_SUB;
        end
      end
      S_I_SUB: begin
        cmd.op     = OP_INV_SUB;
        state_next = S_I_TEST;
      end
      S_DONE: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/rsa_private_exponent_gen.sv
// From input accept, the result waits on the Euclid steps for gcd(p-1,q-1), the lcm divide,
// the range check, the e mod lambda divide and the Euclid steps for the inverse; each divide
// waits on the shared restoring divider. A prime below two or an exponent out of range
// skips ahead to the result.
// One transaction at a time: a new one is taken in the cycle after the result has been taken.
// Synchronous reset returns the controller to idle; data registers are not cleared.
module rsa_private_exponent_gen (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rsapg_pkg::WORD_BITS-1:0]  public_exponent,
  input  logic [rsapg_pkg::PRIME_BITS-1:0] prime_one,
  input  logic [rsapg_pkg::PRIME_BITS-1:0] prime_two,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rsapg_pkg::WORD_BITS-1:0]  modulus,
  output logic [rsapg_pkg::WORD_BITS-1:0]  carmichael_value,
  output logic [rsapg_pkg::WORD_BITS-1:0]  private_exponent,
  output logic                            key_valid
);
  import rsapg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rsapg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rsapg_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .public_exponent  (public_exponent),
    .prime_one        (prime_one),
    .prime_two        (prime_two),
    .modulus          (modulus),
    .carmichael_value (carmichael_value),
    .private_exponent (private_exponent),
    .key_valid        (key_valid)
  );

endmodule
